[hw/rtl/vttv_pkg.sv]
// ----------------------------------------------------------------------------
// vttv_pkg: shared types and constants of the volume tercile trend vote unit
// Holds the bar and result words, the cell control word and helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package vttv_pkg;

    // default history length, and count width covering the largest history
    localparam int WINDOW_MAX_DEF = 64;
    localparam int CNT_W          = 9;
    localparam int SCORE_W        = 9;
    localparam int VOTE_W         = 3;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 6;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OI_USED    = 2'd1;

    // input word, one bar
    typedef struct packed {
        logic signed [31:0] close_price;
        logic               close_valid;
        logic        [31:0] bar_volume;
        logic               volume_valid;
        logic        [31:0] open_interest;
        logic               interest_valid;
    } t_in;

    // output word
    typedef struct packed {
        logic signed [SCORE_W-1:0] score;
        logic                      score_valid;
    } t_out;

    // record that circulates around the row of cells
    typedef struct packed {
        logic        [31:0]       vol;
        logic                     flag;
        logic        [CNT_W-1:0]  lt;
        logic        [CNT_W-1:0]  le;
        logic signed [VOTE_W-1:0] vote;
    } t_circ;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_SHIFT_BAR,
        CELL_INIT_CNT,
        CELL_ROT_CNT,
        CELL_INIT_SEL,
        CELL_ROT,
        CELL_INIT_VOTE
    } t_cell_mode;

    // control broadcast to every cell
    typedef struct packed {
        t_cell_mode       mode;
        logic [CNT_W-1:0] w;
        logic [CNT_W-1:0] seen;
        logic [32:0]      lo2;
        logic [32:0]      hi2;
        logic             oi_used;
    } t_cell_ctl;

    // floor(x/3) for x below 1024 by reciprocal multiply
    function automatic logic [CNT_W-1:0] div3(input logic [CNT_W:0] x);
        logic [19:0] p;
        p = 20'(x) * 20'd683;
        return p[19:11];
    endfunction

endpackage

`default_nettype wire

[hw/rtl/vttv_cell.sv]
// ----------------------------------------------------------------------------
// vttv_cell: one history cell of the trend vote row
// Holds one bar, counts ranks of passing volumes and casts its pair vote.
// ----------------------------------------------------------------------------
`default_nettype none

module vttv_cell
    import vttv_pkg::*;
#(
    parameter int IDX = 0
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_cell_ctl i_ctl,
    input  wire t_in       i_bar,
    input  wire t_in       i_pred,
    input  wire t_circ     i_circ,
    output t_in            o_bar,
    output t_circ          o_circ
);

    t_in              r_bar;
    t_circ            r_circ;
    logic [CNT_W-1:0] r_lt;
    logic [CNT_W-1:0] r_le;

    logic                     in_win;
    logic                     active;
    logic signed [1:0]        dir;
    logic        [32:0]       v2;
    logic signed [VOTE_W-1:0] vote;
    logic                     oi_up;

    // own volume counts toward thresholds when inside the window
    assign in_win = r_bar.volume_valid && (CNT_W'(IDX) < i_ctl.w);

    // pair vote against the older neighbor
    always_comb begin
        active = (CNT_W'(IDX) < i_ctl.w) && (CNT_W'(IDX) < i_ctl.seen) &&
                 r_bar.close_valid && i_pred.close_valid &&
                 r_bar.volume_valid && i_pred.volume_valid;
        if (r_bar.close_price > i_pred.close_price) begin
            dir = 2'sd1;
        end else if (r_bar.close_price < i_pred.close_price) begin
            dir = -2'sd1;
        end else begin
            dir = 2'sd0;
        end
        v2    = {r_bar.bar_volume, 1'b0};
        oi_up = r_bar.interest_valid && i_pred.interest_valid &&
                (r_bar.open_interest > i_pred.open_interest);
        vote  = '0;
        if (active && dir != 2'sd0) begin
            if (v2 >= i_ctl.hi2) begin
                vote = vote + VOTE_W'(dir);
            end else if (v2 <= i_ctl.lo2) begin
                vote = vote - VOTE_W'(dir);
            end
            if (i_ctl.oi_used) begin
                vote = oi_up ? vote + VOTE_W'(dir) : vote - VOTE_W'(dir);
            end
        end
    end

    // bar storage and circulating record
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bar  <= '0;
            r_circ <= '0;
            r_lt   <= '0;
            r_le   <= '0;
        end else begin
            case (i_ctl.mode)
                CELL_SHIFT_BAR: begin
                    r_bar <= i_bar;
                end
                CELL_INIT_CNT: begin
                    r_circ <= '{vol: r_bar.bar_volume, flag: in_win,
                                lt: '0, le: '0, vote: '0};
                    r_lt   <= '0;
                    r_le   <= '0;
                end
                CELL_ROT_CNT: begin
                    if (r_circ.flag && r_circ.vol < r_bar.bar_volume) begin
                        r_lt <= r_lt + 1'b1;
                    end
                    if (r_circ.flag && r_circ.vol <= r_bar.bar_volume) begin
                        r_le <= r_le + 1'b1;
                    end
                    r_circ <= i_circ;
                end
                CELL_INIT_SEL: begin
                    r_circ <= '{vol: r_bar.bar_volume, flag: in_win,
                                lt: r_lt, le: r_le, vote: '0};
                end
                CELL_ROT: begin
                    r_circ <= i_circ;
                end
                CELL_INIT_VOTE: begin
                    r_circ.vote <= vote;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_bar  = r_bar;
    assign o_circ = r_circ;

endmodule

`default_nettype wire

[hw/rtl/volume_tercile_trend_vote_unit.sv]
// ----------------------------------------------------------------------------
// volume_tercile_trend_vote_unit: volume tercile trend vote over a bar window
// Row of history cells with a sequencer for ranks, thresholds and voting.
// ----------------------------------------------------------------------------
// One bar is taken per word; one score word comes out per bar. A new bar is
// taken only once the last one has passed through every step and its score
// is registered at the output: the history row of WINDOW_MAX+1 cells is
// rotated once to rank the volumes, once plus a settling step to pick the
// threshold volumes and once to shift the pair votes out into the adder. A
// new bar is taken while the previous score still waits at the output; the
// next score then waits until that one has been taken, which stalls the
// input for as long.
`default_nettype none

module volume_tercile_trend_vote_unit
    import vttv_pkg::*;
#(
    parameter int WINDOW_MAX = WINDOW_MAX_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire t_in                   i_in_data,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output t_out                       o_out_data,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int DEPTH = WINDOW_MAX + 1;
    localparam logic [CNT_W-1:0] LAST = CNT_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] SEL_END = CNT_W'(DEPTH);

    typedef enum logic [2:0] {
        S_IDLE, S_INITC, S_CNT, S_INITS, S_SEL, S_THR, S_VOTE, S_FIN
    } t_state;

    t_state           r_state;
    logic [CNT_W-1:0] r_cyc;
    logic [CNT_W-1:0] r_m;
    logic [CNT_W-1:0] r_seen;
    logic [CNT_W-1:0] r_w;
    logic [CNT_W-1:0] r_bars_seen;
    logic [CNT_W-1:0] r_rk [4];
    logic [31:0]      r_sv [4];
    logic [32:0]      r_lo2;
    logic [32:0]      r_hi2;
    logic [SCORE_W-1:0] r_acc;
    logic [5:0]       r_win_len;
    logic             r_oi;
    logic             r_out_valid;
    t_out             r_out;

    t_cell_ctl ctl;
    t_in       bar  [DEPTH];
    t_circ     circ [DEPTH];
    t_circ     tail;
    logic [CNT_W-1:0] n_clamp;
    logic [CNT_W-1:0] n_rk [4];
    logic [CNT_W-1:0] r1;
    logic [CNT_W-1:0] r2;

    assign tail = circ[DEPTH-1];

    // row of cells
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        t_in   bin;
        t_in   pin;
        t_circ cin;
        if (i == 0) begin : g_head
            assign bin = i_in_data;
            assign cin = circ[DEPTH-1];
        end else begin : g_body
            assign bin = bar[i-1];
            assign cin = circ[i-1];
        end
        if (i == DEPTH - 1) begin : g_end
            assign pin = '0;
        end else begin : g_mid
            assign pin = bar[i+1];
        end
        vttv_cell #(.IDX(i)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (ctl),
            .i_bar   (bin),
            .i_pred  (pin),
            .i_circ  (cin),
            .o_bar   (bar[i]),
            .o_circ  (circ[i])
        );
    end

    // clamped window length
    assign n_clamp = (CNT_W'(r_win_len) > CNT_W'(WINDOW_MAX - 1)) ?
                     CNT_W'(WINDOW_MAX - 1) : CNT_W'(r_win_len);

    // threshold ranks from the valid volume count
    always_comb begin
        r1 = div3((CNT_W+1)'(r_m) + (CNT_W+1)'(2));
        r2 = div3({r_m, 1'b0});
        if (r_m <= CNT_W'(1)) begin
            n_rk = '{default: '0};
        end else if (r_m <= CNT_W'(3)) begin
            n_rk[0] = '0;
            n_rk[1] = CNT_W'(1);
            n_rk[2] = r_m - CNT_W'(2);
            n_rk[3] = r_m - CNT_W'(1);
        end else begin
            n_rk[0] = r1;
            n_rk[1] = r1;
            n_rk[2] = r2;
            n_rk[3] = r2;
        end
    end

    // cell control
    always_comb begin
        ctl.w       = r_w;
        ctl.seen    = r_seen;
        ctl.lo2     = r_lo2;
        ctl.hi2     = r_hi2;
        ctl.oi_used = r_oi;
        unique case (r_state)
            S_IDLE:  ctl.mode = i_in_valid ? CELL_SHIFT_BAR : CELL_HOLD;
            S_INITC: ctl.mode = CELL_INIT_CNT;
            S_CNT:   ctl.mode = CELL_ROT_CNT;
            S_INITS: ctl.mode = CELL_INIT_SEL;
            S_SEL:   ctl.mode = CELL_ROT;
            S_THR:   ctl.mode = CELL_INIT_VOTE;
            S_VOTE:  ctl.mode = CELL_ROT;
            default: ctl.mode = CELL_HOLD;
        endcase
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // sequencer, config and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cyc       <= '0;
            r_m         <= '0;
            r_seen      <= '0;
            r_w         <= '0;
            r_bars_seen <= '0;
            r_win_len   <= 6'd20;
            r_oi        <= 1'b0;
            r_out_valid <= 1'b0;
            r_acc       <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_WINDOW_LEN: r_win_len <= i_cfg_data;
                    REG_OI_USED:    r_oi      <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
            if (r_out_valid && i_out_ready && r_state != S_FIN) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_seen <= r_bars_seen;
                        r_w    <= ((r_bars_seen < n_clamp) ? r_bars_seen : n_clamp)
                                  + 1'b1;
                        if (r_bars_seen < CNT_W'(DEPTH)) begin
                            r_bars_seen <= r_bars_seen + 1'b1;
                        end
                        r_state <= S_INITC;
                    end
                end
                S_INITC: begin
                    r_m     <= '0;
                    r_cyc   <= '0;
                    r_state <= S_CNT;
                end
                S_CNT: begin
                    r_m   <= r_m + CNT_W'(tail.flag);
                    r_cyc <= r_cyc + 1'b1;
                    if (r_cyc == LAST) begin
                        r_state <= S_INITS;
                    end
                end
                S_INITS: begin
                    r_rk    <= n_rk;
                    r_cyc   <= '0;
                    r_state <= S_SEL;
                end
                S_SEL: begin
                    for (int j = 0; j < 4; j++) begin
                        if (tail.flag && tail.lt <= r_rk[j] && r_rk[j] < tail.le) begin
                            r_sv[j] <= tail.vol;
                        end
                    end
                    r_cyc <= r_cyc + 1'b1;
                    // an extra settling step lets the last pick land before the sums
                    if (r_cyc == SEL_END) begin
                        r_state <= S_THR;
                    end
                end
                S_THR: begin
                    r_cyc   <= '0;
                    r_acc   <= '0;
                    r_state <= S_VOTE;
                end
                S_VOTE: begin
                    r_acc <= r_acc + {{(SCORE_W-VOTE_W){tail.vote[VOTE_W-1]}},
                                      tail.vote};
                    r_cyc <= r_cyc + 1'b1;
                    if (r_cyc == LAST) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid       <= 1'b1;
                        r_out.score_valid <= (r_m != '0);
                        r_out.score       <= (r_m != '0) ? r_acc : '0;
                        r_state           <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // thresholds, doubled
    always_ff @(posedge i_clk) begin
        if (r_state == S_SEL && r_cyc == SEL_END) begin
            r_lo2 <= 33'(r_sv[0]) + 33'(r_sv[1]);
            r_hi2 <= 33'(r_sv[2]) + 33'(r_sv[3]);
        end
    end

`ifndef SYNTHESIS
    // an accepted bar always starts the ranking pass
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_INITC))
        else $error("bar accepted without starting ranking");

    // a rotation pass is not cut short
    a_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CNT && r_cyc != LAST) |=> (r_state == S_CNT))
        else $error("ranking pass cut short");

    // valid volume count never exceeds the history depth
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEL) |-> (r_m <= CNT_W'(DEPTH)))
        else $error("volume count out of range");
`endif

endmodule

`default_nettype wire

[dv/tb_volume_tercile_trend_vote_unit.sv]
// ----------------------------------------------------------------------------
// tb_volume_tercile_trend_vote_unit: self-checking bench of the vote unit
// Feeds bar words through the valid/ready port. A bit-exact score model
// predicts each result, and every output word is checked field by field.
// Covers directed corners, register settings and random bars under stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_volume_tercile_trend_vote_unit;
    import vttv_pkg::*;

    localparam int DEPTH      = WINDOW_MAX_DEF + 1;
    localparam int IDLE_LIMIT = 20000;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_ready;
    t_in                   i_in_data;
    logic                  o_out_valid;
    logic                  i_out_ready;
    t_out                  o_out_data;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    volume_tercile_trend_vote_unit u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // clock
    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    // score model state
    logic [31:0] hist_close[DEPTH];
    bit          hist_close_ok[DEPTH];
    logic [31:0] hist_vol[DEPTH];
    bit          hist_vol_ok[DEPTH];
    logic [31:0] hist_oi[DEPTH];
    bit          hist_oi_ok[DEPTH];
    int          bar_ptr;
    int          bars_taken;
    logic [5:0]  lookback;
    bit          oi_votes;

    t_out score_q[$];
    int   fails;
    int   bars_sent;
    int   scores_seen;
    int   sender_idle;
    int   receiver_idle;
    int   hold_req;
    int   hold_left;
    int   quiet_cycles;
    logic [31:0] walk_close;
    logic [31:0] walk_oi;

    // model reset
    function automatic void score_model_reset();
        for (int i = 0; i < DEPTH; i++) begin
            hist_close_ok[i] = 0;
            hist_vol_ok[i]   = 0;
            hist_oi_ok[i]    = 0;
            hist_close[i]    = '0;
            hist_vol[i]      = '0;
            hist_oi[i]       = '0;
        end
        bar_ptr    = 0;
        bars_taken = 0;
        lookback   = 6'd20;
        oi_votes   = 0;
    endfunction

    // take one bar into the model history and compute its score word
    function automatic t_out predict_score(input t_in b);
        int          cur;
        int          prior;
        int          span;
        int          a;
        int          p;
        int          dir;
        int          sc;
        longint      vols[$];
        longint      lo2;
        longint      hi2;
        longint      v2;
        bit          oi_up;
        t_out        r;
        cur = bar_ptr;
        hist_close[cur]    = b.close_price;
        hist_close_ok[cur] = b.close_valid;
        hist_vol[cur]      = b.bar_volume;
        hist_vol_ok[cur]   = b.volume_valid;
        hist_oi[cur]       = b.open_interest;
        hist_oi_ok[cur]    = b.interest_valid;
        bar_ptr = (cur + 1) % DEPTH;
        prior = bars_taken;
        if (bars_taken < DEPTH) bars_taken++;
        span = ((prior < int'(lookback)) ? prior : int'(lookback)) + 1;
        for (int k = 0; k < span; k++) begin
            a = (cur + DEPTH - k) % DEPTH;
            if (hist_vol_ok[a]) vols = {vols, longint'(hist_vol[a])};
        end
        r.score = '0;
        r.score_valid = 1'b0;
        if (vols.size() == 0) return r;
        vols.sort();
        if (vols.size() == 1) begin
            lo2 = 2 * vols[0];
            hi2 = lo2;
        end else if (vols.size() <= 3) begin
            lo2 = vols[0] + vols[1];
            hi2 = vols[vols.size()-2] + vols[vols.size()-1];
        end else begin
            lo2 = 2 * vols[(vols.size() + 2) / 3];
            hi2 = 2 * vols[(2 * vols.size()) / 3];
        end
        sc = 0;
        for (int k = 0; k < span; k++) begin
            a = (cur + DEPTH - k) % DEPTH;
            p = (cur + DEPTH - k - 1) % DEPTH;
            if (k >= prior) continue;
            if (!hist_close_ok[a] || !hist_close_ok[p]) continue;
            if (!hist_vol_ok[a] || !hist_vol_ok[p]) continue;
            if ($signed(hist_close[a]) > $signed(hist_close[p])) dir = 1;
            else if ($signed(hist_close[a]) < $signed(hist_close[p])) dir = -1;
            else continue;
            v2 = 2 * longint'(hist_vol[a]);
            if (v2 >= hi2) sc += dir;
            else if (v2 <= lo2) sc -= dir;
            if (oi_votes) begin
                oi_up = hist_oi_ok[a] && hist_oi_ok[p] && (hist_oi[a] > hist_oi[p]);
                sc += oi_up ? dir : -dir;
            end
        end
        r.score = sc[SCORE_W-1:0];
        r.score_valid = 1'b1;
        return r;
    endfunction

    function automatic t_in make_bar(input logic [31:0] c, input bit cv,
                                     input logic [31:0] v, input bit vv,
                                     input logic [31:0] o, input bit ov);
        t_in b;
        b.close_price    = c;
        b.close_valid    = cv;
        b.bar_volume     = v;
        b.volume_valid   = vv;
        b.open_interest  = o;
        b.interest_valid = ov;
        return b;
    endfunction

    // random bar: small close and interest steps for ties, some full-range values
    function automatic t_in random_bar();
        logic [31:0] c;
        logic [31:0] v;
        logic [31:0] o;
        int          r;
        r = $urandom_range(99);
        if (r < 6) c = $urandom;
        else c = walk_close + 32'($urandom_range(6)) - 32'd3;
        walk_close = c;
        r = $urandom_range(99);
        if (r < 10) v = $urandom;
        else if (r < 13) v = '0;
        else if (r < 16) v = '1;
        else v = 32'($urandom_range(1, 8) * 100);
        r = $urandom_range(99);
        if (r < 8) o = $urandom;
        else o = walk_oi + 32'($urandom_range(4)) - 32'd2;
        walk_oi = o;
        return make_bar(c, $urandom_range(99) < 90, v, $urandom_range(99) < 88,
                        o, $urandom_range(99) < 85);
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch on %s: got %0d, want %0d (score word %0d)",
                 what, got, want, scores_seen);
        fails++;
    endtask

    // send one word: random idle gap, then hold valid until accepted
    task automatic send_bar(input t_in b);
        @(negedge i_clk);
        while ($urandom_range(99) < sender_idle) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= b;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        score_q = {score_q, predict_score(b)};
        bars_sent++;
    endtask

    task automatic stop_sending();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        stop_sending();
        while (score_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [5:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        if (idx == REG_WINDOW_LEN) lookback = data;
        else if (idx == REG_OI_USED) oi_votes = data[0];
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_random(input int count);
        for (int i = 0; i < count; i++) send_bar(random_bar());
    endtask

    // receiver ready, with a counted long hold-off on request
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (hold_req > 0) begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= receiver_idle);
            end
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            scores_seen++;
            if (score_q.size() == 0) begin
                report_mismatch("unexpected score word", scores_seen, 0);
            end else begin
                want = score_q.pop_front();
                if (o_out_data.score_valid !== want.score_valid)
                    report_mismatch("score_valid", o_out_data.score_valid, want.score_valid);
                if (o_out_data.score !== want.score)
                    report_mismatch("score", int'(o_out_data.score), int'(want.score));
            end
        end
    end

    // watchdog on cycles with no word moving
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || !i_rst_n)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("tb_volume_tercile_trend_vote_unit: FAIL");
            $finish;
        end
    end

    // corners at default settings: first bar, extremes, invalid flags, ties
    task automatic test_directed_corners();
        send_bar(make_bar(32'd100, 1, 32'd500, 1, 32'd10, 1));
        send_bar(make_bar(32'h7FFF_FFFF, 1, 32'hFFFF_FFFF, 1, 32'hFFFF_FFFF, 1));
        send_bar(make_bar(32'h8000_0000, 1, 32'd0, 1, 32'd0, 1));
        send_bar(make_bar(32'h8000_0000, 1, 32'd7, 1, 32'd0, 1));
        send_bar(make_bar(32'd5, 0, 32'd300, 1, 32'd5, 1));
        send_bar(make_bar(32'd6, 1, 32'd300, 0, 32'd6, 0));
        send_bar(make_bar(32'd7, 1, 32'hFFFF_FFFF, 1, 32'd7, 1));
        send_bar(make_bar(32'd3, 1, 32'd1, 1, 32'd1, 1));
        send_bar(make_bar(32'hFFFF_FFFF, 1, 32'd400, 1, 32'd9, 1));
        wait_drained();
        // interest votes, with an invalid interest counting as not rising
        cfg_write(REG_OI_USED, 6'd1);
        send_bar(make_bar(32'd10, 1, 32'd100, 1, 32'd50, 1));
        send_bar(make_bar(32'd20, 1, 32'd900, 1, 32'd60, 0));
        send_bar(make_bar(32'd15, 1, 32'd100, 1, 32'd40, 1));
        send_bar(make_bar(32'd15, 1, 32'd500, 1, 32'd90, 1));
        send_bar(make_bar(32'd30, 1, 32'd500, 1, 32'hFFFF_FFFF, 1));
        wait_drained();
        // writes to unused indexes are ignored
        cfg_write(2'd2, 6'h3F);
        cfg_write(2'd3, 6'h2A);
        send_bar(make_bar(32'd31, 1, 32'd200, 1, 32'd1, 1));
        wait_drained();
    endtask

    // zero, one and full lookback, and a window with no valid volume
    task automatic test_window_lengths();
        cfg_write(REG_WINDOW_LEN, 6'd0);
        cfg_write(REG_OI_USED, 6'd0);
        send_bar(make_bar(32'd1, 1, 32'd5, 0, 32'd1, 1));
        send_bar(make_bar(32'd2, 1, 32'd5, 1, 32'd1, 1));
        send_bar(make_bar(32'd1, 1, 32'd5, 1, 32'd1, 1));
        send_random(20);
        wait_drained();
        cfg_write(REG_WINDOW_LEN, 6'd1);
        send_bar(make_bar(32'd1, 1, 32'd5, 0, 32'd1, 1));
        send_bar(make_bar(32'd2, 1, 32'd5, 0, 32'd1, 1));
        send_random(30);
        wait_drained();
        cfg_write(REG_WINDOW_LEN, 6'd63);
        cfg_write(REG_OI_USED, 6'd1);
        send_random(150);
        wait_drained();
    endtask

    // long receiver hold-off with the sender still offering words
    task automatic test_backpressure();
        sender_idle   = 0;
        receiver_idle = 0;
        cfg_write(REG_WINDOW_LEN, 6'd5);
        hold_req = 1500;
        send_random(12);
        wait_drained();
    endtask

    // random bars across idle patterns and settings
    task automatic test_random_bars();
        sender_idle   = 30;
        receiver_idle = 80;
        cfg_write(REG_WINDOW_LEN, 6'($urandom_range(2, 40)));
        cfg_write(REG_OI_USED, 6'($urandom_range(1)));
        send_random(220);
        wait_drained();
        sender_idle   = 80;
        receiver_idle = 30;
        cfg_write(REG_WINDOW_LEN, 6'd63);
        cfg_write(REG_OI_USED, 6'd1);
        send_random(220);
        wait_drained();
        sender_idle   = 0;
        receiver_idle = 0;
        cfg_write(REG_WINDOW_LEN, 6'($urandom_range(0, 12)));
        cfg_write(REG_OI_USED, 6'd0);
        send_random(220);
        wait_drained();
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_in_data     = '0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = '0;
        i_cfg_data    = '0;
        fails         = 0;
        bars_sent     = 0;
        scores_seen   = 0;
        hold_req      = 0;
        hold_left     = 0;
        quiet_cycles  = 0;
        sender_idle   = 0;
        receiver_idle = 0;
        walk_close    = 32'd1000;
        walk_oi       = 32'd5000;
        score_model_reset();
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_corners();
        test_window_lengths();
        test_backpressure();
        test_random_bars();

        stop_sending();
        while (score_q.size() != 0) @(posedge i_clk);
        repeat (250) @(posedge i_clk);
        $display("bars sent %0d, scores checked %0d, %0d mismatches", bars_sent,
                 scores_seen, fails);
        $display("covered lookback 0/1/63, interest votes on and off, long output stall");
        if (fails == 0 && score_q.size() == 0) begin
            $display("tb_volume_tercile_trend_vote_unit: PASS");
        end else begin
            $display("tb_volume_tercile_trend_vote_unit: FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire

[files.f]
hw/rtl/vttv_pkg.sv
hw/rtl/vttv_cell.sv
hw/rtl/volume_tercile_trend_vote_unit.sv
dv/tb_volume_tercile_trend_vote_unit.sv
